@@ rtl/core/itoa_pkg.sv @@
// Package for the integer to ASCII converter: widths, character codes and
// the digit to character mapping. No dependencies.
`default_nettype none
package itoa_pkg;

  localparam int unsigned VALUE_WIDTH = 32;
  localparam int unsigned RADIX_W     = 6;
  localparam int unsigned CHAR_W      = 8;
  localparam int unsigned CNT_W       = $clog2(VALUE_WIDTH + 1);
  localparam int unsigned BIT_W       = $clog2(VALUE_WIDTH);

  localparam logic [RADIX_W-1:0] RADIX_MIN  = RADIX_W'(2);
  localparam logic [RADIX_W-1:0] RADIX_MAX  = RADIX_W'(36);
  localparam logic [RADIX_W-1:0] DIGIT_TEN  = RADIX_W'(10);
  localparam logic [CHAR_W-1:0]  CHAR_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0]  LETTER_GAP = 8'd7;
  localparam logic [CHAR_W-1:0]  CHAR_MINUS = 8'h2D;

  typedef logic [RADIX_W-1:0] digit_t;

  function automatic logic [CHAR_W-1:0] digit_char(input digit_t d);
    logic [CHAR_W-1:0] c;
    c = CHAR_ZERO + CHAR_W'(d);
    if (d >= DIGIT_TEN) begin
      c = c + LETTER_GAP;
    end
    return c;
  endfunction

endpackage
`default_nettype wire

@@ rtl/core/integer_to_ascii_radix.sv @@
// Integer to ASCII converter, any radix from 2 to 36, digit-serial divider.
// Depends on itoa_pkg.
//
// Usage: present value, radix and signed_mode on the in_ channel; the text
// of the number leaves on the out_ channel as one character per item, most
// significant first, with out_last on the final character. A negative value
// in signed mode is preceded by '-'. Radix is saturated to 2..36.
// Each digit takes one restoring division of the remaining quotient by the
// radix, one quotient bit per cycle; a single divider is shared by all
// digits. A new item is taken once the last character sits in the output
// register, so the block does not accept a new item while it still has
// characters of the previous one to convert or to load.
// Characters are held in a last-in first-out shift stack and emitted from
// a single output register; when out_ready is low the character holds and
// conversion of the remaining characters pauses.
// Reset (rst_n low, synchronous) returns the block to idle and empties the
// output register.
`default_nettype none
module integer_to_ascii_radix (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_ready,
  input  wire logic [31:0]                    in_value,
  input  wire logic [5:0]                     in_radix,
  input  wire logic                           in_signed_mode,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [7:0]                          out_character,
  output logic                                out_last
);

  localparam int unsigned VW = itoa_pkg::VALUE_WIDTH;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t                                 state_r, state_nxt;
  logic [VW-1:0]                          quo_r, quo_nxt;
  logic [itoa_pkg::RADIX_W-1:0]           rem_r, rem_nxt;
  logic [itoa_pkg::RADIX_W-1:0]           radix_r, radix_nxt;
  logic [itoa_pkg::BIT_W-1:0]             bit_r, bit_nxt;
  logic [itoa_pkg::CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                                   neg_r, neg_nxt;
  itoa_pkg::digit_t                       stk_r [VW];
  itoa_pkg::digit_t                       stk_nxt [VW];
  logic                                   out_valid_r, out_valid_nxt;
  logic [itoa_pkg::CHAR_W-1:0]            out_char_r, out_char_nxt;
  logic                                   out_last_r, out_last_nxt;

  logic [itoa_pkg::RADIX_W:0]             trial;
  logic                                   qbit;
  logic [itoa_pkg::RADIX_W-1:0]           rem_step;
  logic [VW-1:0]                          quo_step;
  logic [VW-1:0]                          value_w;
  logic                                   in_neg;
  logic                                   load_ok;

  assign in_ready      = (state_r == ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_character = out_char_r;
  assign out_last      = out_last_r;

  assign value_w  = in_value[VW-1:0];
  assign in_neg   = in_signed_mode & value_w[VW-1];
  assign trial    = {rem_r, quo_r[VW-1]};
  assign qbit     = (trial >= {1'b0, radix_r});
  assign rem_step = qbit ? itoa_pkg::RADIX_W'(trial - {1'b0, radix_r})
                         : trial[itoa_pkg::RADIX_W-1:0];
  assign quo_step = {quo_r[VW-2:0], qbit};
  assign load_ok  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    quo_nxt       = quo_r;
    rem_nxt       = rem_r;
    radix_nxt     = radix_r;
    bit_nxt       = bit_r;
    cnt_nxt       = cnt_r;
    neg_nxt       = neg_r;
    stk_nxt       = stk_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          neg_nxt   = in_neg;
          quo_nxt   = in_neg ? (~value_w + VW'(1)) : value_w;
          rem_nxt   = '0;
          bit_nxt   = '0;
          cnt_nxt   = '0;
          priority if (in_radix < itoa_pkg::RADIX_MIN) begin
            radix_nxt = itoa_pkg::RADIX_MIN;
          end else if (in_radix > itoa_pkg::RADIX_MAX) begin
            radix_nxt = itoa_pkg::RADIX_MAX;
          end else begin
            radix_nxt = in_radix;
          end
          state_nxt = ST_DIV;
        end
      end
      ST_DIV: begin
        quo_nxt = quo_step;
        rem_nxt = rem_step;
        bit_nxt = bit_r + itoa_pkg::BIT_W'(1);
        if (bit_r == itoa_pkg::BIT_W'(VW - 1)) begin
          // push the digit
          for (int i = VW - 1; i > 0; i--) begin
            stk_nxt[i] = stk_r[i-1];
          end
          stk_nxt[0] = rem_step;
          cnt_nxt    = cnt_r + itoa_pkg::CNT_W'(1);
          rem_nxt    = '0;
          bit_nxt    = '0;
          if (quo_step == '0) begin
            state_nxt = neg_r ? ST_SIGN : ST_EMIT;
          end
        end
      end
      ST_SIGN: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itoa_pkg::CHAR_MINUS;
          out_last_nxt  = 1'b0;
          state_nxt     = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (load_ok) begin
          out_valid_nxt = 1'b1;
          out_char_nxt  = itoa_pkg::digit_char(stk_r[0]);
          out_last_nxt  = (cnt_r == itoa_pkg::CNT_W'(1));
          // pop the digit
          for (int i = 0; i < VW - 1; i++) begin
            stk_nxt[i] = stk_r[i+1];
          end
          cnt_nxt = cnt_r - itoa_pkg::CNT_W'(1);
          if (cnt_r == itoa_pkg::CNT_W'(1)) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    quo_r      <= quo_nxt;
    rem_r      <= rem_nxt;
    radix_r    <= radix_nxt;
    bit_r      <= bit_nxt;
    cnt_r      <= cnt_nxt;
    neg_r      <= neg_nxt;
    stk_r      <= stk_nxt;
    out_char_r <= out_char_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule
`default_nettype wire

@@ tb/sv/integer_to_ascii_radix_checker.sv @@
// Checker for integer_to_ascii_radix: predicts the ASCII text of each number
// taken on the in_ channel and compares it with the out_ channel, character by
// character. Depends on itoa_pkg for widths and character codes.
module itoa_text_checker (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  input  logic                              in_ready,
  input  logic [itoa_pkg::VALUE_WIDTH-1:0]  in_value,
  input  logic [itoa_pkg::RADIX_W-1:0]      in_radix,
  input  logic                              in_signed_mode,
  input  logic                              out_valid,
  input  logic                              out_ready,
  input  logic [itoa_pkg::CHAR_W-1:0]       out_character,
  input  logic                              out_last,
  output int                                failures,
  output int                                chars_pending,
  output int                                numbers_seen,
  output int                                chars_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [itoa_pkg::CHAR_W-1:0] character;
    logic                        last;
  } text_char_t;

  text_char_t expected_text[$];
  int         fail_count = 0;
  int         number_count = 0;
  int         char_count = 0;

  function automatic void predict_text(input logic [itoa_pkg::VALUE_WIDTH-1:0] raw,
                                       input logic [itoa_pkg::RADIX_W-1:0] radix_in,
                                       input logic as_signed);
    logic [itoa_pkg::VALUE_WIDTH-1:0] magnitude;
    logic [itoa_pkg::RADIX_W-1:0]     base;
    logic [itoa_pkg::RADIX_W-1:0]     digit;
    logic [itoa_pkg::CHAR_W-1:0]      ch;
    logic [itoa_pkg::CHAR_W-1:0]      digits[$];
    logic                             negative;
    text_char_t                       entry;
    base = radix_in;
    if (base < itoa_pkg::RADIX_MIN) begin
      base = itoa_pkg::RADIX_MIN;
    end
    if (base > itoa_pkg::RADIX_MAX) begin
      base = itoa_pkg::RADIX_MAX;
    end
    negative  = as_signed && raw[itoa_pkg::VALUE_WIDTH-1];
    magnitude = negative ? (~raw + 1'b1) : raw;
    do begin
      digit = itoa_pkg::RADIX_W'(magnitude % itoa_pkg::VALUE_WIDTH'(base));
      ch    = itoa_pkg::CHAR_ZERO + itoa_pkg::CHAR_W'(digit);
      if (digit >= itoa_pkg::DIGIT_TEN) begin
        ch = ch + itoa_pkg::LETTER_GAP;
      end
      digits.push_front(ch);
      magnitude = magnitude / itoa_pkg::VALUE_WIDTH'(base);
    end while (magnitude != '0);
    if (negative) begin
      entry.character = itoa_pkg::CHAR_MINUS;
      entry.last      = 1'b0;
      expected_text.push_back(entry);
    end
    foreach (digits[i]) begin
      entry.character = digits[i];
      entry.last      = (i == digits.size() - 1);
      expected_text.push_back(entry);
    end
  endfunction

  always @(posedge clk) begin
    text_char_t want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        char_count++;
        if (expected_text.size() == 0) begin
          $error("unexpected character %h last %b", out_character, out_last);
          fail_count++;
        end else begin
          want = expected_text.pop_front();
          if (out_character !== want.character) begin
            $error("character: expected %h, got %h", want.character, out_character);
            fail_count++;
          end
          if (out_last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_last);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        number_count++;
        predict_text(in_value, in_radix, in_signed_mode);
      end
    end
    failures      <= fail_count;
    chars_pending <= expected_text.size();
    numbers_seen  <= number_count;
    chars_seen    <= char_count;
  end

endmodule

@@ tb/sv/integer_to_ascii_radix_tb.sv @@
// Testbench top for integer_to_ascii_radix: drives numbers with random gaps and
// output stalls, and gives the verdict from itoa_text_checker.
// Depends on itoa_pkg, the block and the checker.
module integer_to_ascii_radix_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_ITEMS = 127;
  localparam int IDLE_LIMIT   = 20000;
  localparam int HOLD_CYCLES  = 3000;
  localparam int HOLD_AFTER   = 40;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic [itoa_pkg::VALUE_WIDTH-1:0] in_value;
  logic [itoa_pkg::RADIX_W-1:0]     in_radix;
  logic                             in_signed_mode;
  logic                             out_valid;
  logic                             out_ready;
  logic [itoa_pkg::CHAR_W-1:0]      out_character;
  logic                             out_last;

  int failures;
  int chars_pending;
  int numbers_seen;
  int chars_seen;
  int numbers_taken = 0;
  int idle_cycles = 0;
  bit hold_done = 1'b0;

  always #6ns clk = ~clk;

  integer_to_ascii_radix dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .in_signed_mode (in_signed_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_last       (out_last)
  );

  itoa_text_checker checker_i (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_value       (in_value),
    .in_radix       (in_radix),
    .in_signed_mode (in_signed_mode),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_character  (out_character),
    .out_last       (out_last),
    .failures       (failures),
    .chars_pending  (chars_pending),
    .numbers_seen   (numbers_seen),
    .chars_seen     (chars_seen)
  );

  function automatic int next_gap();
    int r;
    r = $urandom_range(0, 19);
    if (r < 12) begin
      return 0;
    end
    if (r < 18) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(20, 80);
  endfunction

  task automatic send_number(input logic [itoa_pkg::VALUE_WIDTH-1:0] value,
                             input logic [itoa_pkg::RADIX_W-1:0] radix,
                             input logic as_signed);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_value       <= value;
    in_radix       <= radix;
    in_signed_mode <= as_signed;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n && in_valid && in_ready) begin
      numbers_taken <= numbers_taken + 1;
    end
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // receiver: ready bursts, random stalls, one long hold-off to back up the input
  initial begin
    int n;
    out_ready <= 1'b0;
    wait (rst_n === 1'b1);
    @(posedge clk);
    forever begin
      if (!hold_done && numbers_taken >= HOLD_AFTER) begin
        hold_done = 1'b1;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      n = $urandom_range(50, 300);
      if ($urandom_range(0, 9) < 3) begin
        out_ready <= 1'b1;
        repeat (n) @(posedge clk);
      end else if ($urandom_range(0, 19) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(100, 400)) @(posedge clk);
      end else begin
        repeat (n) begin
          out_ready <= ($urandom_range(0, 3) != 0);
          @(posedge clk);
        end
      end
    end
  end

  initial begin
    logic [itoa_pkg::VALUE_WIDTH-1:0] value;
    logic [itoa_pkg::RADIX_W-1:0]     radix;
    rst_n          <= 1'b0;
    in_valid       <= 1'b0;
    in_value       <= '0;
    in_radix       <= '0;
    in_signed_mode <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    send_number(32'h0000_0000, 6'd10, 1'b0);
    send_number(32'h0000_0000, 6'd10, 1'b1);
    send_number(32'hFFFF_FFFF, 6'd2,  1'b0);
    send_number(32'hFFFF_FFFF, 6'd10, 1'b1);
    send_number(32'h8000_0000, 6'd10, 1'b1);
    send_number(32'h8000_0000, 6'd2,  1'b1);
    send_number(32'h8000_0000, 6'd36, 1'b1);
    send_number(32'h8000_0000, 6'd16, 1'b0);
    send_number(32'h7FFF_FFFF, 6'd16, 1'b1);
    send_number(32'hFFFF_FFFF, 6'd36, 1'b0);
    send_number(32'd35,        6'd36, 1'b0);
    send_number(32'd9,         6'd10, 1'b0);
    send_number(32'd10,        6'd16, 1'b0);
    send_number(32'd255,       6'd0,  1'b0);
    send_number(32'd255,       6'd1,  1'b1);
    send_number(32'd1295,      6'd37, 1'b0);
    send_number(32'd1295,      6'd63, 1'b1);
    send_number(32'hDEAD_BEEF, 6'd16, 1'b0);
    send_number(32'hDEAD_BEEF, 6'd16, 1'b1);
    send_number(32'h1234_5678, 6'd8,  1'b0);
    send_number(32'hAAAA_AAAA, 6'd3,  1'b1);
    send_number(32'h5555_5555, 6'd7,  1'b0);
    send_number(32'd1,         6'd2,  1'b0);

    repeat (RANDOM_ITEMS) begin
      case ($urandom_range(0, 3))
        0: value = $urandom;
        1: value = $urandom_range(0, 1000);
        2: value = -$urandom_range(1, 1000);
        default: value = $urandom >> $urandom_range(0, 31);
      endcase
      if ($urandom_range(0, 19) < 17) begin
        radix = itoa_pkg::RADIX_W'($urandom_range(itoa_pkg::RADIX_MIN, itoa_pkg::RADIX_MAX));
      end else begin
        radix = itoa_pkg::RADIX_W'($urandom_range(0, 63));
      end
      send_number(value, radix, 1'($urandom_range(0, 1)));
    end
    in_valid <= 1'b0;

    @(posedge clk);
    while (chars_pending != 0) @(posedge clk);
    repeat (50) @(posedge clk);

    $display("Converted %0d numbers into %0d characters, radices 0 to 63,", numbers_seen,
             chars_seen);
    $display("signed and unsigned reads, with random stalls and one long output hold-off");
    if (failures == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
